[rtl/encoder_angle_tracker_observer_unit_assert.svh]
// Assertion macros shared by the angle tracker RTL.
// Each macro expects i_clk and i_rst_n in the using module.
`ifndef ENCODER_ANGLE_TRACKER_OBSERVER_UNIT_ASSERT_SVH
`define ENCODER_ANGLE_TRACKER_OBSERVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EATO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EATO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EATO_ASSERT_NOW(lbl, ante, cons, msg)
`define EATO_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/eato_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eato_pkg;

    // fixed field widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PP_BITS        = 7;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_SHIFT     = 16;
    localparam int MT_BITS        = 32;
    localparam int SPEED_BITS     = 30;
    localparam int ERR_BITS       = 48;

    // observer innovation limit, +/-(2^47 - 1)
    localparam logic signed [ERR_BITS-1:0] ERR_POS = {1'b0, {(ERR_BITS-1){1'b1}}};
    localparam logic signed [ERR_BITS-1:0] ERR_NEG = {1'b1, {(ERR_BITS-2){1'b0}}, 1'b1};

    // register reset values
    localparam logic [PP_BITS-1:0]   POLE_PAIRS_RESET    = 7'd7;
    localparam logic [GAIN_BITS-1:0] POSITION_GAIN_RESET = 16'd2059;
    localparam logic [GAIN_BITS-1:0] SPEED_GAIN_RESET    = 16'd16;

    // configuration register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ZERO_OFFSET       = 3'd0,
        CFG_REVERSE_DIRECTION = 3'd1,
        CFG_POLE_PAIRS        = 3'd2,
        CFG_POSITION_GAIN     = 3'd3,
        CFG_SPEED_GAIN        = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [GAIN_BITS-1:0] position_gain;
        logic [GAIN_BITS-1:0] speed_gain;
    } t_gain_cfg;

    // item held between the angle front end and the observer
    typedef struct packed {
        logic                      valid;
        logic                      elec_valid;
        logic signed [MT_BITS-1:0] multiturn;
    } t_front_item;

endpackage

`default_nettype wire

[rtl/eato_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_angle_tracker_observer_unit_assert.svh"

module eato_front
    import eato_pkg::*;
#(
    parameter int ANGLE_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [ANGLE_BITS-1:0] i_sensor_angle,
    input  logic                  i_read_error,
    input  logic [ANGLE_BITS-1:0] i_zero_offset,
    input  logic                  i_reverse_direction,
    input  logic [PP_BITS-1:0]    i_pole_pairs,
    input  logic                  i_drain,
    output t_front_item           o_item,
    output logic [ANGLE_BITS-1:0] o_elec_angle
);

    // offset angle; it doubles as the previous angle of the next item
    logic signed [ANGLE_BITS:0]   r_offset;
    logic signed [ANGLE_BITS:0]   n_offset;
    logic signed [ANGLE_BITS:0]   offset_new;
    logic signed [ANGLE_BITS+1:0] delta;
    logic [ANGLE_BITS-1:0]        turn_low;
    logic                         wrap_neg;
    logic signed [ANGLE_BITS:0]   step;
    logic signed [MT_BITS:0]      acc_sum;
    logic signed [MT_BITS-1:0]    r_acc;
    logic signed [MT_BITS-1:0]    n_acc;
    logic [ANGLE_BITS-1:0]        e_mech;
    logic [ANGLE_BITS-1:0]        e_dir;
    logic [ANGLE_BITS+PP_BITS-1:0] elec_prod;
    logic [ANGLE_BITS-1:0]        elec;
    logic                         r_valid;
    logic                         r_elec_valid;
    logic [ANGLE_BITS-1:0]        r_elec;

    // zero offset and hold on read error
    always_comb begin
        offset_new = $signed({1'b0, i_sensor_angle}) - $signed({1'b0, i_zero_offset});
        n_offset   = i_read_error ? r_offset : offset_new;
    end

    // unwrap to within half a turn; an exact half turn keeps the sign of the change
    always_comb begin
        delta    = (ANGLE_BITS+2)'(n_offset) - (ANGLE_BITS+2)'(r_offset);
        turn_low = delta[ANGLE_BITS-1:0];
        wrap_neg = turn_low[ANGLE_BITS-1] &&
                   ((|turn_low[ANGLE_BITS-2:0]) || delta[ANGLE_BITS+1]);
        step     = {wrap_neg, turn_low};
    end

    // saturating multi-turn accumulator, sign inverted
    always_comb begin
        acc_sum = (MT_BITS+1)'(r_acc) - (MT_BITS+1)'(step);
        if (acc_sum[MT_BITS] != acc_sum[MT_BITS-1]) begin
            n_acc = acc_sum[MT_BITS] ? {1'b1, {(MT_BITS-1){1'b0}}}
                                     : {1'b0, {(MT_BITS-1){1'b1}}};
        end else begin
            n_acc = acc_sum[MT_BITS-1:0];
        end
    end

    // electrical angle: direction, pole pairs, modulo one turn
    always_comb begin
        e_mech    = n_offset[ANGLE_BITS-1:0];
        e_dir     = i_reverse_direction ? (~e_mech + {{(ANGLE_BITS-1){1'b0}}, 1'b1})
                                        : e_mech;
        elec_prod = {{PP_BITS{1'b0}}, e_dir} * {{ANGLE_BITS{1'b0}}, i_pole_pairs};
        elec      = i_read_error ? '0 : elec_prod[ANGLE_BITS-1:0];
    end

    // tracker state and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_acc    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_take) begin
                r_offset <= n_offset;
                r_acc    <= n_acc;
            end
            if (i_take) begin
                r_valid <= 1'b1;
            end else if (i_drain) begin
                r_valid <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_elec       <= elec;
            r_elec_valid <= !i_read_error;
        end
    end

    // the accumulator register is the stage's multi-turn field
    assign o_item.valid      = r_valid;
    assign o_item.elec_valid = r_elec_valid;
    assign o_item.multiturn  = r_acc;
    assign o_elec_angle      = r_elec;

    `EATO_ASSERT_NEXT(a_error_holds_turns, i_take && i_read_error, r_acc == $past(r_acc), "accumulator moved on a failed read")
    `EATO_ASSERT_NEXT(a_error_holds_offset, i_take && i_read_error, r_offset == $past(r_offset), "offset angle moved on a failed read")

endmodule

`default_nettype wire

[rtl/eato_observer.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_angle_tracker_observer_unit_assert.svh"

module eato_observer
    import eato_pkg::*;
#(
    parameter int ANGLE_BITS    = 14,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_gain_cfg                    i_gain,
    input  t_front_item                  i_item,
    input  logic [ANGLE_BITS-1:0]        i_elec_angle,
    input  logic                         i_out_stall,
    output logic                         o_drain,
    output logic                         o_out_valid,
    output logic [ANGLE_BITS-1:0]        o_elec_angle,
    output logic                         o_electrical_valid,
    output logic signed [MT_BITS-1:0]    o_multiturn_angle,
    output logic signed [SPEED_BITS-1:0] o_observed_speed
);

    localparam int PW = MT_BITS + FRACTION_BITS;
    localparam int EW = (PW + 2 > ERR_BITS + 2) ? PW + 2 : ERR_BITS + 2;
    localparam int CW = ERR_BITS + GAIN_BITS - GAIN_SHIFT + 1;

    logic signed [PW-1:0]              r_pos;
    logic signed [PW-1:0]              n_pos;
    logic signed [SPEED_BITS-1:0]      r_speed;
    logic signed [SPEED_BITS-1:0]      n_speed;
    logic                              r_started;
    logic signed [PW-1:0]              meas;
    logic signed [PW:0]                pred;
    logic signed [EW-1:0]              err_full;
    logic                              err_fit;
    logic signed [ERR_BITS-1:0]        err;
    logic signed [GAIN_BITS:0]         pgain;
    logic signed [GAIN_BITS:0]         sgain;
    logic signed [ERR_BITS+GAIN_BITS:0] pprod;
    logic signed [ERR_BITS+GAIN_BITS:0] sprod;
    logic signed [CW-1:0]              pcorr;
    logic signed [CW-1:0]              scorr;
    logic signed [EW-1:0]              pos_sum;
    logic signed [EW-1:0]              spd_sum;
    logic signed [PW-1:0]              pos_run;
    logic signed [SPEED_BITS-1:0]      spd_run;
    logic                              out_load;
    logic                              r_out_valid;
    logic [ANGLE_BITS-1:0]             r_out_elec;
    logic                              r_out_elec_valid;
    logic signed [MT_BITS-1:0]         r_out_mt;

    // output register frees when empty or taken
    assign out_load = !r_out_valid || !i_out_stall;
    assign o_drain  = i_item.valid && out_load;

    // prediction and clamped innovation
    always_comb begin
        meas     = {i_item.multiturn, {FRACTION_BITS{1'b0}}};
        pred     = (PW+1)'(r_pos) + (PW+1)'(r_speed);
        err_full = EW'(meas) - EW'(pred);
        err_fit  = (&err_full[EW-1:ERR_BITS-1]) || (~|err_full[EW-1:ERR_BITS-1]);
        if (err_full[EW-1] && (!err_fit || (~|err_full[ERR_BITS-2:0]))) begin
            err = ERR_NEG;
        end else if (!err_full[EW-1] && !err_fit) begin
            err = ERR_POS;
        end else begin
            err = err_full[ERR_BITS-1:0];
        end
    end

    // gain products, floored by the arithmetic shift
    always_comb begin
        pgain = {1'b0, i_gain.position_gain};
        sgain = {1'b0, i_gain.speed_gain};
        pprod = err * pgain;
        sprod = err * sgain;
        pcorr = pprod[ERR_BITS+GAIN_BITS:GAIN_SHIFT];
        scorr = sprod[ERR_BITS+GAIN_BITS:GAIN_SHIFT];
    end

    // corrected position and speed with saturation
    always_comb begin
        pos_sum = EW'(pred) + EW'(pcorr);
        spd_sum = EW'(r_speed) + EW'(scorr);
        if ((&pos_sum[EW-1:PW-1]) || (~|pos_sum[EW-1:PW-1])) begin
            pos_run = pos_sum[PW-1:0];
        end else begin
            pos_run = pos_sum[EW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        if ((&spd_sum[EW-1:SPEED_BITS-1]) || (~|spd_sum[EW-1:SPEED_BITS-1])) begin
            spd_run = spd_sum[SPEED_BITS-1:0];
        end else begin
            spd_run = spd_sum[EW-1] ? {1'b1, {(SPEED_BITS-1){1'b0}}}
                                    : {1'b0, {(SPEED_BITS-1){1'b1}}};
        end
    end

    // first item seeds the observer
    always_comb begin
        n_pos   = r_started ? pos_run : meas;
        n_speed = r_started ? spd_run : '0;
    end

    // observer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_speed     <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_drain) begin
                r_pos     <= n_pos;
                r_speed   <= n_speed;
                r_started <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= i_item.valid;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_drain) begin
            r_out_elec       <= i_elec_angle;
            r_out_elec_valid <= i_item.elec_valid;
            r_out_mt         <= i_item.multiturn;
        end
    end

    // speed state changes only together with the output register
    assign o_out_valid        = r_out_valid;
    assign o_elec_angle       = r_out_elec;
    assign o_electrical_valid = r_out_elec_valid;
    assign o_multiturn_angle  = r_out_mt;
    assign o_observed_speed   = r_speed;

    `EATO_ASSERT_NEXT(a_seed_zero_speed, o_drain && !r_started, r_started && r_speed == '0, "observer seed left nonzero speed")
    `EATO_ASSERT_NEXT(a_started_sticks, r_started, r_started, "observer lost its seed flag")

endmodule

`default_nettype wire

[rtl/encoder_angle_tracker_observer_unit.sv]
// Encoder angle tracker with multi-turn unwrap and position observer.
//
// Input channel: i_in_valid / o_in_stall with i_sensor_angle and i_read_error,
// one sensor item per control tick. Output channel: o_out_valid / i_out_stall
// with the electrical angle, its valid flag, the multi-turn angle and the
// observer speed, one result per input item, in order.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
// i_cfg_data; write only while no item is in flight.
//
// Pipeline: two register stages, the front-end stage and the observer output
// register. Throughput is one item per cycle unless the receiver stalls, set
// by the observer update, which closes its position/speed loop
// combinationally around its state registers (48 x 16 gain multipliers).
// When the receiver stalls, the output holds and one more item is still taken
// into the front-end stage; o_in_stall rises only when both stages are full.
// Synchronous reset clears the tracker and observer state, loads the register
// defaults (pole pairs 7, gains 2059 and 16) and empties the pipeline. The
// first item after reset seeds the observer with zero speed.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_angle_tracker_observer_unit_assert.svh"

module encoder_angle_tracker_observer_unit
    import eato_pkg::*;
#(
    parameter int ANGLE_BITS    = 14,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ANGLE_BITS-1:0]        i_sensor_angle,
    input  logic                         i_read_error,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ANGLE_BITS-1:0]        o_elec_angle,
    output logic                         o_electrical_valid,
    output logic signed [MT_BITS-1:0]    o_multiturn_angle,
    output logic signed [SPEED_BITS-1:0] o_observed_speed,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

    logic [ANGLE_BITS-1:0] r_zero_offset;
    logic                  r_reverse_direction;
    logic [PP_BITS-1:0]    r_pole_pairs;
    t_gain_cfg             r_gain;
    logic                  cfg_write;
    logic                  in_take;
    logic                  drain;
    t_front_item           front_item;
    logic [ANGLE_BITS-1:0] front_elec;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset        <= '0;
            r_reverse_direction  <= 1'b0;
            r_pole_pairs         <= POLE_PAIRS_RESET;
            r_gain.position_gain <= POSITION_GAIN_RESET;
            r_gain.speed_gain    <= SPEED_GAIN_RESET;
        end else if (cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ZERO_OFFSET:       r_zero_offset        <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_REVERSE_DIRECTION: r_reverse_direction  <= i_cfg_data[0];
                CFG_POLE_PAIRS:        r_pole_pairs         <= i_cfg_data[PP_BITS-1:0];
                CFG_POSITION_GAIN:     r_gain.position_gain <= i_cfg_data[GAIN_BITS-1:0];
                CFG_SPEED_GAIN:        r_gain.speed_gain    <= i_cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // stall only when the front stage is full and cannot move on
    assign o_in_stall = front_item.valid && !drain;
    assign in_take    = i_in_valid && !o_in_stall;

    eato_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_take              (in_take),
        .i_sensor_angle      (i_sensor_angle),
        .i_read_error        (i_read_error),
        .i_zero_offset       (r_zero_offset),
        .i_reverse_direction (r_reverse_direction),
        .i_pole_pairs        (r_pole_pairs),
        .i_drain             (drain),
        .o_item              (front_item),
        .o_elec_angle        (front_elec)
    );

    eato_observer #(
        .ANGLE_BITS    (ANGLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_observer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_gain             (r_gain),
        .i_item             (front_item),
        .i_elec_angle       (front_elec),
        .i_out_stall        (i_out_stall),
        .o_drain            (drain),
        .o_out_valid        (o_out_valid),
        .o_elec_angle       (o_elec_angle),
        .o_electrical_valid (o_electrical_valid),
        .o_multiturn_angle  (o_multiturn_angle),
        .o_observed_speed   (o_observed_speed)
    );

    `EATO_ASSERT_NOW(a_stall_needs_full, o_in_stall, o_out_valid && i_out_stall, "input stalled while the output could move")
    `EATO_ASSERT_NOW(a_bad_read_zero_angle, o_out_valid && !o_electrical_valid, o_elec_angle == '0, "invalid item carries an angle")

endmodule

`default_nettype wire
